/* hw/rtl/shp_pkg.sv */
package shp_pkg;

    // sizing of the line memories and the window
    localparam int MAX_ROW_ELEMENTS = 8192;
    localparam int MAX_CHANNELS     = 4;

    localparam int PIX_W     = 8;
    localparam int COL_W     = $clog2(MAX_ROW_ELEMENTS);
    localparam int LEN_W     = COL_W + 1;
    localparam int ROW_W     = 12;
    localparam int CH_W      = 3;
    localparam int CSEL_W    = $clog2(MAX_CHANNELS);
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // word kinds on the input channel
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_FLUSH  = 1'b1
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } t_cfg_idx;

    // frame geometry derived from the configuration registers
    typedef struct packed {
        logic [CH_W-1:0]   chans;
        logic [CSEL_W-1:0] c_m1;
        logic [CH_W:0]     two_c;
        logic [COL_W-1:0]  r_last;
        logic [LEN_W-1:0]  r_plus_c;
        logic [ROW_W-1:0]  h_last;
    } t_geom;

    // per-word control travelling with an accepted word
    typedef struct packed {
        logic is_sample;
        logic emit;
        logic interior;
        logic last;
    } t_item;

    // line memory access control
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr2_en;
        logic [COL_W-1:0] wr2_addr;
    } t_mem_ctl;

endpackage

/* hw/rtl/shp_ifs.sv */
// input channel: samples and flush ticks
interface shp_in_if import shp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [PIX_W-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink (input valid, input kind, input sample, output ready);
endinterface

// output channel: sharpened bytes
interface shp_out_if import shp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

/* hw/rtl/sharpen_3x3_laplacian_filter.sv */
// channel   dir  handshake      word
// i_in      in   valid/ready    kind, sample
// o_out     out  valid/ready    pixel_out, frame_last
// i_cfg_*   in   write enable   register index, data
//
// one word per clock sustained while the output is ready; a sample's result leaves
// through the stage-one and output registers, behind two 8192-byte line memories
// each line memory has one write and one registered read per clock; the
// second line is written in the cycle after the first is read
// reset clears counters, configuration registers and handshake state; line memories are not cleared
// a stalled output holds one word and one more in flight before input stalls
module sharpen_3x3_laplacian_filter import shp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    shp_in_if.sink               i_in,
    shp_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_geom            w_geom;
    logic             w_restart;
    logic             w_accept;
    logic             w_in_ready;
    logic             w_load;
    t_item            w_item;
    t_mem_ctl         w_mem;
    logic [PIX_W-1:0] w_line1;
    logic [PIX_W-1:0] w_line2;

    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    // configuration registers
    shp_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (i_cfg_we),
        .i_idx     (i_cfg_idx),
        .i_data    (i_cfg_data),
        .o_geom    (w_geom),
        .o_restart (w_restart)
    );

    // raster position and drain control
    shp_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (w_geom),
        .i_restart (w_restart),
        .i_accept  (w_accept),
        .i_kind    (i_in.kind),
        .o_load    (w_load),
        .o_item    (w_item),
        .o_mem     (w_mem)
    );

    // line one: the previous row
    shp_line_ram u_line1 (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem.rd_en),
        .i_wr_addr (w_mem.rd_addr),
        .i_wr_data (i_in.sample),
        .i_rd_en   (w_mem.rd_en),
        .i_rd_addr (w_mem.rd_addr),
        .o_rd_data (w_line1)
    );

    // line two: the row before that
    shp_line_ram u_line2 (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem.wr2_en),
        .i_wr_addr (w_mem.wr2_addr),
        .i_wr_data (w_line1),
        .i_rd_en   (w_mem.rd_en),
        .i_rd_addr (w_mem.rd_addr),
        .o_rd_data (w_line2)
    );

    // window, arithmetic and output register
    shp_kernel u_kernel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_item      (w_item),
        .i_sample    (i_in.sample),
        .i_line1     (w_line1),
        .i_line2     (w_line2),
        .i_c_m1      (w_geom.c_m1),
        .i_out_ready (o_out.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (o_out.valid),
        .o_pixel     (o_out.pixel_out),
        .o_last      (o_out.frame_last)
    );

    // the frame's last word is a drained border word
    a_last_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.frame_last |-> o_out.pixel_out == '0)
        else $error("frame_last word carries a non-zero pixel");

    // a flagged word comes from a flush, never from a sample
    a_last_from_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_item.last |-> w_item.emit && !w_item.is_sample && !w_item.interior)
        else $error("frame_last raised on a sample word");

    // a row always spans at least three pixels
    a_row_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({10'd0, w_geom.two_c} + {11'd0, w_geom.chans}) <= ({1'b0, w_geom.r_last} + 14'd1))
        else $error("row shorter than three pixels");

    // the second line is written in the cycle after a sample is stored
    a_line2_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem.rd_en |=> w_mem.wr2_en && w_mem.wr2_addr == $past(w_mem.rd_addr))
        else $error("second line write lost");

endmodule

/* hw/rtl/shp_cfg.sv */
module shp_cfg import shp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [CFG_W-1:0]     i_data,
    output t_geom                o_geom,
    output logic                 o_restart
);

    localparam logic [11:0] RST_WIDTH  = 12'd640;
    localparam logic [12:0] RST_HEIGHT = 13'd480;
    localparam logic [2:0]  RST_CHANS  = 3'd3;

    logic [11:0] r_width,  n_width;
    logic [12:0] r_height, n_height;
    logic [2:0]  r_chans,  n_chans;
    t_geom       r_geom;
    logic        w_hit;

    // widest row in pixels that fits the line memory
    function automatic logic [LEN_W-1:0] width_limit(input logic [CH_W-1:0] c);
        case (c)
            3'd1:    return LEN_W'(MAX_ROW_ELEMENTS / 1);
            3'd2:    return LEN_W'(MAX_ROW_ELEMENTS / 2);
            3'd3:    return LEN_W'(MAX_ROW_ELEMENTS / 3);
            default: return LEN_W'(MAX_ROW_ELEMENTS / 4);
        endcase
    endfunction

    // clamp the registers and work out the row length in elements
    function automatic t_geom derive_geom(input logic [11:0] w, input logic [12:0] h,
                                          input logic [2:0] c);
        logic [CH_W-1:0]       ce;
        logic [12:0]           he;
        logic [LEN_W-1:0]      we;
        logic [LEN_W-1:0]      lim;
        logic [LEN_W+CH_W-1:0] prod;
        t_geom                 g;
        ce = (c == '0) ? CH_W'(1) : ((c > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : c);
        he = (h < 13'd3) ? 13'd3 : ((h > 13'd4096) ? 13'd4096 : h);
        we = (w < 12'd3) ? LEN_W'(3) : LEN_W'(w);
        lim = width_limit(ce);
        if (we > lim) begin
            we = lim;
        end
        prod = {{CH_W{1'b0}}, we} * {{LEN_W{1'b0}}, ce};
        g.chans    = ce;
        g.c_m1     = CSEL_W'(ce - CH_W'(1));
        g.two_c    = {ce, 1'b0};
        g.r_last   = COL_W'(prod[LEN_W-1:0] - LEN_W'(1));
        g.r_plus_c = prod[LEN_W-1:0] + LEN_W'(ce);
        g.h_last   = ROW_W'(he - 13'd1);
        return g;
    endfunction

    // register write decode
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_chans  = r_chans;
        w_hit    = 1'b0;
        if (i_we) begin
            unique case (i_idx)
                CFG_FRAME_WIDTH: begin
                    n_width = i_data[11:0];
                    w_hit   = 1'b1;
                end
                CFG_FRAME_HEIGHT: begin
                    n_height = i_data[12:0];
                    w_hit    = 1'b1;
                end
                CFG_CHANNEL_COUNT: begin
                    n_chans = i_data[2:0];
                    w_hit   = 1'b1;
                end
                default: begin
                    w_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_chans  <= RST_CHANS;
            r_geom   <= derive_geom(RST_WIDTH, RST_HEIGHT, RST_CHANS);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_chans  <= n_chans;
            r_geom   <= derive_geom(n_width, n_height, n_chans);
        end
    end

    assign o_geom    = r_geom;
    assign o_restart = w_hit;

endmodule

/* hw/rtl/shp_seq.sv */
module shp_seq import shp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_geom    i_geom,
    input  logic     i_restart,
    input  logic     i_accept,
    input  logic     i_kind,
    output logic     o_load,
    output t_item    o_item,
    output t_mem_ctl o_mem
);

    logic [COL_W-1:0] r_col,  n_col;
    logic [ROW_W-1:0] r_row,  n_row;
    logic [LEN_W-1:0] r_pend, n_pend;
    logic             r_wr2;
    logic [COL_W-1:0] r_wr2_addr;

    logic w_is_flush;
    logic w_eff_sample;
    logic w_eff_flush;
    logic w_col_ge_c;
    logic w_col_ge_2c;
    logic w_row_ge1;
    logic w_row_ge2;

    // classify the word at the input
    always_comb begin
        w_is_flush   = (i_kind == KIND_FLUSH);
        w_eff_sample = !w_is_flush && (r_pend == '0);
        w_eff_flush  = w_is_flush && (r_pend != '0);
        w_col_ge_c   = r_col >= COL_W'(i_geom.chans);
        w_col_ge_2c  = r_col >= COL_W'(i_geom.two_c);
        w_row_ge1    = r_row != '0;
        w_row_ge2    = r_row >= ROW_W'(2);
    end

    // result position lags by one row plus one pixel
    always_comb begin
        o_item.is_sample = w_eff_sample;
        o_item.emit      = w_eff_flush ||
                           (w_eff_sample && (w_col_ge_c ? w_row_ge1 : w_row_ge2));
        o_item.interior  = w_eff_sample && w_col_ge_2c && w_row_ge2;
        o_item.last      = w_eff_flush && (r_pend == LEN_W'(1));
        o_load           = i_accept && (w_eff_sample || w_eff_flush);
    end

    // raster counters and drain count
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_pend = r_pend;
        if (i_restart) begin
            n_col  = '0;
            n_row  = '0;
            n_pend = '0;
        end else if (i_accept && w_eff_sample) begin
            if (r_col == i_geom.r_last) begin
                n_col = '0;
                if (r_row == i_geom.h_last) begin
                    n_row  = '0;
                    n_pend = i_geom.r_plus_c;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end else if (i_accept && w_eff_flush) begin
            n_pend = r_pend - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
            r_wr2  <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
            r_wr2  <= i_accept && w_eff_sample;
        end
    end

    // second line is written in the following cycle from the first line's read data
    always_ff @(posedge i_clk) begin
        r_wr2_addr <= r_col;
    end

    assign o_mem.rd_en    = i_accept && w_eff_sample;
    assign o_mem.rd_addr  = r_col;
    assign o_mem.wr2_en   = r_wr2;
    assign o_mem.wr2_addr = r_wr2_addr;

endmodule

/* hw/rtl/shp_line_ram.sv */
module shp_line_ram import shp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_wr_addr,
    input  logic [PIX_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    output logic [PIX_W-1:0] o_rd_data
);

    logic [PIX_W-1:0] r_mem [MAX_ROW_ELEMENTS];
    logic [PIX_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/shp_kernel.sv */
module shp_kernel import shp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_item             i_item,
    input  logic [PIX_W-1:0]  i_sample,
    input  logic [PIX_W-1:0]  i_line1,
    input  logic [PIX_W-1:0]  i_line2,
    input  logic [CSEL_W-1:0] i_c_m1,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic [PIX_W-1:0]  o_pixel,
    output logic              o_last
);

    localparam int ACC_W = PIX_W + 4;

    logic             r_s1_valid;
    t_item            r_s1_item;
    logic [PIX_W-1:0] r_s1_sample;
    logic [PIX_W-1:0] r_dn [MAX_CHANNELS];
    logic [PIX_W-1:0] r_l1 [2*MAX_CHANNELS];
    logic [PIX_W-1:0] r_l2 [MAX_CHANNELS];
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_last;

    logic                    w_advance;
    logic                    w_s1_free;
    logic                    w_shift;
    logic [PIX_W-1:0]        w_up;
    logic [PIX_W-1:0]        w_down;
    logic [PIX_W-1:0]        w_left;
    logic [PIX_W-1:0]        w_right;
    logic [PIX_W-1:0]        w_cur;
    logic [ACC_W-1:0]        w_pos;
    logic [ACC_W-1:0]        w_neg;
    logic signed [ACC_W-1:0] w_acc;
    logic [PIX_W-1:0]        w_pix;

    // pipeline flow
    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_s1_free  = !r_s1_valid || w_advance;
    assign w_shift    = w_advance && r_s1_valid && r_s1_item.is_sample;
    assign o_in_ready = w_s1_free;

    // window taps: one pixel and one row apart in the stream
    always_comb begin
        w_down  = r_dn[i_c_m1];
        w_right = i_line1;
        w_cur   = r_l1[i_c_m1];
        w_left  = r_l1[{i_c_m1, 1'b1}];
        w_up    = r_l2[i_c_m1];
    end

    // 5 x centre less the four neighbours, clipped to a byte; border words give zero
    always_comb begin
        w_pos = ACC_W'({w_cur, 2'b00}) + ACC_W'(w_cur);
        w_neg = ACC_W'(w_up) + ACC_W'(w_down) + ACC_W'(w_left) + ACC_W'(w_right);
        w_acc = $signed(w_pos - w_neg);
        if (!r_s1_item.interior || w_acc[ACC_W-1]) begin
            w_pix = '0;
        end else if (|w_acc[ACC_W-2:PIX_W]) begin
            w_pix = '1;
        end else begin
            w_pix = w_acc[PIX_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_load;
            end
            if (w_advance) begin
                r_out_valid <= r_s1_valid && r_s1_item.emit;
            end
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_item   <= i_item;
            r_s1_sample <= i_sample;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid && r_s1_item.emit) begin
            r_out_pix  <= w_pix;
            r_out_last <= r_s1_item.last;
        end
    end

    // per-channel delay chains behind the sample and the two lines
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_dn[0] <= r_s1_sample;
            r_l1[0] <= i_line1;
            r_l2[0] <= i_line2;
            for (int i = 1; i < MAX_CHANNELS; i++) begin
                r_dn[i] <= r_dn[i-1];
                r_l2[i] <= r_l2[i-1];
            end
            for (int i = 1; i < 2*MAX_CHANNELS; i++) begin
                r_l1[i] <= r_l1[i-1];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_out_pix;
    assign o_last      = r_out_last;

endmodule
